// ===== src/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, widths and the controller/datapath command and status
// structures.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 5;
    localparam int DATA_W         = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic apply_bump;
        logic apply_evict;
        logic apply_insert;
        logic write_value;
    } lfu_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic victim_ok;
        logic free_ok;
        logic full;
        logic cap_zero;
        logic is_put;
    } lfu_stat_t;

endpackage

// ===== src/lfu_datapath.sv =====
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry storage, a one-entry-per-cycle scan for key match, victim and free
// slot, and the rank and count updates applied after the scan.
// ----------------------------------------------------------------------------
module lfu_datapath #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfu_pkg::lfu_ctrl_t            ctrl,
    output lfu_pkg::lfu_stat_t            stat,
    input  logic                          cmd,
    input  logic [lfu_pkg::DATA_W-1:0]    key,
    input  logic [lfu_pkg::DATA_W-1:0]    value,
    input  logic [lfu_pkg::CAP_W-1:0]     capacity,
    output logic [lfu_pkg::DATA_W-1:0]    found_value
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SCAN_W = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                        valid_reg [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  key_mem   [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  value_mem [ENTRIES];
    logic [COUNT_BITS-1:0]       count_mem [ENTRIES];
    logic [IDX_W-1:0]            rank_mem  [ENTRIES];
    logic [CNT_W-1:0]            fill_reg;

    logic                        cmd_reg;
    logic [lfu_pkg::DATA_W-1:0]  key_reg;
    logic [lfu_pkg::DATA_W-1:0]  value_reg;
    logic [CNT_W-1:0]            cap_reg;
    logic [SCAN_W-1:0]           scan_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            match_reg;
    logic                        victim_ok_reg;
    logic [IDX_W-1:0]            victim_reg;
    logic [COUNT_BITS-1:0]       vcount_reg;
    logic [IDX_W-1:0]            vrank_reg;
    logic                        free_ok_reg;
    logic [IDX_W-1:0]            free_reg;

    logic [IDX_W-1:0]            cur;
    logic                        better;
    logic [IDX_W-1:0]            ins_idx;

    assign cur = scan_reg[IDX_W-1:0];

    always_comb
    begin
        better = !victim_ok_reg || (count_mem[cur] < vcount_reg)
                 || (count_mem[cur] == vcount_reg && rank_mem[cur] > vrank_reg);
    end

    assign ins_idx = victim_ok_reg && stat.full ? victim_reg : free_reg;

    assign stat.scan_done = (scan_reg == SCAN_W'(ENTRIES));
    assign stat.found     = found_reg;
    assign stat.victim_ok = victim_ok_reg;
    assign stat.free_ok   = free_ok_reg;
    assign stat.full      = (fill_reg >= cap_reg);
    assign stat.cap_zero  = (cap_reg == '0);
    assign stat.is_put    = (cmd_reg == lfu_pkg::CMD_PUT);
    assign found_value    = value_mem[match_reg];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= cmd;
            key_reg   <= key;
            value_reg <= value;
            if (32'(capacity) > ENTRIES)
                cap_reg <= CNT_W'(ENTRIES);
            else
                cap_reg <= CNT_W'(capacity);
        end
        if (ctrl.scan_step && valid_reg[cur])
        begin
            if (key_mem[cur] == key_reg)
                match_reg <= cur;
            if (better)
            begin
                victim_reg <= cur;
                vcount_reg <= count_mem[cur];
                vrank_reg  <= rank_mem[cur];
            end
        end
        if (ctrl.scan_step && !valid_reg[cur] && !free_ok_reg)
            free_reg <= cur;
        if (ctrl.write_value)
            value_mem[match_reg] <= value_reg;
        if (ctrl.apply_bump && count_mem[match_reg] != COUNT_MAX)
            count_mem[match_reg] <= count_mem[match_reg] + 1'b1;
        if (ctrl.apply_insert)
        begin
            key_mem[ins_idx]   <= key_reg;
            value_mem[ins_idx] <= value_reg;
            count_mem[ins_idx] <= COUNT_BITS'(1);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ctrl.apply_bump)
            begin
                if (IDX_W'(i) == match_reg)
                    rank_mem[i] <= '0;
                else if (valid_reg[i] && rank_mem[i] < rank_mem[match_reg])
                    rank_mem[i] <= rank_mem[i] + 1'b1;
            end
            if (ctrl.apply_insert)
            begin
                if (IDX_W'(i) == ins_idx)
                    rank_mem[i] <= '0;
                else if (valid_reg[i] && !(ctrl.apply_evict && IDX_W'(i) == victim_reg))
                begin
                    if (ctrl.apply_evict && rank_mem[i] > vrank_reg)
                        rank_mem[i] <= rank_mem[i];
                    else
                        rank_mem[i] <= rank_mem[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= 1'b0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            victim_ok_reg <= 1'b0;
            free_ok_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.scan_clear)
            begin
                scan_reg      <= '0;
                found_reg     <= 1'b0;
                victim_ok_reg <= 1'b0;
                free_ok_reg   <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (valid_reg[cur])
                begin
                    if (key_mem[cur] == key_reg)
                        found_reg <= 1'b1;
                    victim_ok_reg <= 1'b1;
                end
                else
                    free_ok_reg <= 1'b1;
            end
            if (ctrl.apply_insert)
            begin
                valid_reg[ins_idx] <= 1'b1;
                if (!ctrl.apply_evict)
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

endmodule

// ===== src/lfu_controller.sv =====
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences load, scan and update for one command and issues the result
// strobe.
// ----------------------------------------------------------------------------
module lfu_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lfu_pkg::lfu_stat_t         stat,
    output lfu_pkg::lfu_ctrl_t         ctrl,
    input  logic [lfu_pkg::DATA_W-1:0] found_value,
    output logic                       done,
    output logic                       hit,
    output logic [lfu_pkg::DATA_W-1:0] read_value,
    output logic                       evicted
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load       = start;
                ctrl.scan_clear = start;
            end
            ST_SCAN:
                ctrl.scan_step = !stat.scan_done;
            ST_APPLY:
            begin
                if (stat.found)
                begin
                    if (!stat.is_put || !stat.cap_zero)
                        ctrl.apply_bump = 1'b1;
                    ctrl.write_value = stat.is_put && !stat.cap_zero;
                end
                else if (stat.is_put && !stat.cap_zero)
                begin
                    ctrl.apply_evict  = stat.full && stat.victim_ok;
                    ctrl.apply_insert = (stat.full && stat.victim_ok) || stat.free_ok;
                end
            end
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done       <= 1'b0;
            hit        <= 1'b0;
            read_value <= '0;
            evicted    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                        state_reg <= ST_SCAN;
                ST_SCAN:
                    if (stat.scan_done)
                        state_reg <= ST_APPLY;
                ST_APPLY:
                begin
                    state_reg  <= ST_IDLE;
                    done       <= 1'b1;
                    hit        <= stat.found;
                    read_value <= (stat.found && !stat.is_put) ? found_value
                                                               : lfu_pkg::MISS_VALUE;
                    evicted    <= !stat.found && stat.is_put && !stat.cap_zero
                                  && stat.full;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/lfu_cache_table.sv =====
// A command runs from start through a scan of the table, one entry per cycle,
// and an apply step to the done strobe. A new command is taken once busy falls,
// so the table does not take a command before it is through with the last.
// The done strobe is high for one cycle and cannot be stalled by the receiver.
// Reset clears all valid flags and the fill count at once; capacity resets to 16.
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative key-value cache with least-frequently-used replacement
// and least-recently-used tie break.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic signed [31:0]          key,
    input  logic signed [31:0]          value,
    output logic                        done,
    output logic                        hit,
    output logic signed [31:0]          read_value,
    output logic                        evicted,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]   cfg_data
);

    logic [lfu_pkg::CAP_W-1:0]  capacity_reg;
    lfu_pkg::lfu_ctrl_t         ctrl;
    lfu_pkg::lfu_stat_t         stat;
    logic [lfu_pkg::DATA_W-1:0] found_value;
    logic [lfu_pkg::DATA_W-1:0] rd;

    assign cfg_ready  = 1'b1;
    assign read_value = signed'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= lfu_pkg::CAP_RESET;
        else if (cfg_valid)
            capacity_reg <= cfg_data;
    end

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cmd         (cmd),
        .key         (unsigned'(key)),
        .value       (unsigned'(value)),
        .capacity    (capacity_reg),
        .found_value (found_value)
    );

    lfu_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .stat        (stat),
        .ctrl        (ctrl),
        .found_value (found_value),
        .done        (done),
        .hit         (hit),
        .read_value  (rd),
        .evicted     (evicted)
    );

endmodule
